// ===== design/json_object_line_parser_core_macros.svh =====
// Assertion macros shared by the line parser modules.
// No dependencies; included by the files that assert.
`ifndef JSON_OBJECT_LINE_PARSER_CORE_MACROS_SVH
`define JSON_OBJECT_LINE_PARSER_CORE_MACROS_SVH

// condition must never hold outside reset
`define JOLP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// same-cycle implication
`define JOLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JOLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/jolp_pkg.sv =====
// Types and codes for the JSON object line parser.
// No dependencies; imported by every module of the block.
package jolp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  char_out;
    logic [31:0] number;
    logic [3:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // one result without its run marker
  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  char_out;
    logic [31:0] number;
    logic [3:0]  error_code;
  } res_t;

  localparam int MaxRun = 3;

  // all results caused by one byte
  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MaxRun-1:0]     res;
  } run_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = QAw + 1;

  localparam logic [3:0] EV_KEY_BYTE  = 4'd0;
  localparam logic [3:0] EV_KEY_END   = 4'd1;
  localparam logic [3:0] EV_VAL_BYTE  = 4'd2;
  localparam logic [3:0] EV_VAL_END   = 4'd3;
  localparam logic [3:0] EV_ARR_START = 4'd4;
  localparam logic [3:0] EV_ELEMENT   = 4'd5;
  localparam logic [3:0] EV_ARR_END   = 4'd6;
  localparam logic [3:0] EV_DONE      = 4'd7;
  localparam logic [3:0] EV_ERROR     = 4'd8;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_EXP_CHAR    = 4'd1;
  localparam logic [3:0] ERR_EXP_STRING  = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC     = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd4;
  localparam logic [3:0] ERR_UNI_BIG     = 4'd5;
  localparam logic [3:0] ERR_CTRL_CHAR   = 4'd6;
  localparam logic [3:0] ERR_UNTERM      = 4'd7;
  localparam logic [3:0] ERR_EXP_NUMBER  = 4'd8;
  localparam logic [3:0] ERR_OVERFLOW    = 4'd9;
  localparam logic [3:0] ERR_ARR_SEP     = 4'd10;
  localparam logic [3:0] ERR_UNSUPPORTED = 4'd11;
  localparam logic [3:0] ERR_FIELD_SEP   = 4'd12;
  localparam logic [3:0] ERR_TRAILING    = 4'd13;

  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [15:0] ASCII_MAX  = 16'h007f;

endpackage

// ===== design/jolp_front.sv =====
// Front end: byte classifier and parse state machine; builds one run per byte.
// Depends on jolp_pkg and the assertion macro header.
`include "json_object_line_parser_core_macros.svh"

module jolp_front #(
  parameter int NUMBER_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  jolp_pkg::in_item_t in_item,
  output logic              push,
  output jolp_pkg::run_t    run
);
  import jolp_pkg::*;

  localparam int PW   = NUMBER_BITS + 4;
  localparam int AccW = (NUMBER_BITS > 32) ? NUMBER_BITS : 32;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [16:0] {
    PH_OPEN        = 17'h00001,
    PH_FIRST_KEY   = 17'h00002,
    PH_KEY         = 17'h00004,
    PH_KSTR        = 17'h00008,
    PH_KESC        = 17'h00010,
    PH_KHEX        = 17'h00020,
    PH_COLON       = 17'h00040,
    PH_VALUE       = 17'h00080,
    PH_VSTR        = 17'h00100,
    PH_VESC        = 17'h00200,
    PH_VHEX        = 17'h00400,
    PH_ARR_FIRST   = 17'h00800,
    PH_ARR_NEXT    = 17'h01000,
    PH_NUM         = 17'h02000,
    PH_AFTER_NUM   = 17'h04000,
    PH_AFTER_VALUE = 17'h08000,
    PH_TRAIL       = 17'h10000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             hex_left_r, hex_left_nxt;
  logic [15:0]            cp_r, cp_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic                   skip_r, skip_nxt;

  logic [7:0]    c;
  logic          last;
  logic          is_ws, is_dig, is_hex, val_str, do_after;
  logic [3:0]    hex_v, err;
  logic [7:0]    esc_d;
  logic [15:0]   cp_shift;
  logic [PW-1:0] prod;
  logic [AccW-1:0] acc_ext;
  logic [1:0]    n;

  function automatic res_t mk_res(logic [3:0] ev, logic [7:0] ch, logic [31:0] num,
                                  logic [3:0] ec);
    res_t r;
    r.event_res  = ev;
    r.char_out   = ch;
    r.number     = num;
    r.error_code = ec;
    return r;
  endfunction

  function automatic logic [3:0] end_code(phase_t p);
    logic [3:0] e;
    case (p)
      PH_OPEN, PH_COLON:         e = ERR_EXP_CHAR;
      PH_FIRST_KEY, PH_KEY:      e = ERR_EXP_STRING;
      PH_VALUE:                  e = ERR_UNSUPPORTED;
      PH_ARR_FIRST, PH_ARR_NEXT: e = ERR_EXP_NUMBER;
      default:                   e = ERR_UNTERM;
    endcase
    return e;
  endfunction

  assign c        = in_item.in_byte;
  assign last     = in_item.end_of_text;
  assign is_ws    = c inside {8'h20, [8'h09:8'h0d]};
  assign is_dig   = c inside {[8'h30:8'h39]};
  assign is_hex   = is_dig || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
  assign hex_v    = is_dig ? c[3:0] : (c[3:0] + 4'd9);
  assign cp_shift = {cp_r[11:0], hex_v};
  assign prod     = (PW'(acc_r) << 3) + (PW'(acc_r) << 1) + PW'(c[3:0]);
  assign val_str  = (phase_r == PH_VSTR) || (phase_r == PH_VESC) || (phase_r == PH_VHEX);

  always_comb begin
    phase_nxt    = phase_r;
    hex_left_nxt = hex_left_r;
    cp_nxt       = cp_r;
    acc_nxt      = acc_r;
    skip_nxt     = skip_r;
    err          = ERR_NONE;
    do_after     = 1'b0;
    esc_d        = c;
    n            = 2'd0;
    run          = '0;
    acc_ext      = AccW'(acc_r);

    if (!skip_r) begin
      case (phase_r)
        PH_OPEN: begin
          if (c == CH_LBRACE) phase_nxt = PH_FIRST_KEY;
          else if (!is_ws) err = ERR_EXP_CHAR;
        end
        PH_FIRST_KEY, PH_KEY: begin
          if (is_ws) begin
          end else if (c == CH_RBRACE && phase_r == PH_FIRST_KEY) begin
            phase_nxt = PH_TRAIL;
          end else if (c == CH_QUOTE) begin
            phase_nxt = PH_KSTR;
          end else begin
            err = ERR_EXP_STRING;
          end
        end
        PH_KSTR, PH_VSTR: begin
          if (c == CH_QUOTE) begin
            run.res[n] = mk_res(val_str ? EV_VAL_END : EV_KEY_END, 8'd0, 32'd0, ERR_NONE);
            n = n + 2'd1;
            phase_nxt = val_str ? PH_AFTER_VALUE : PH_COLON;
          end else if (c == CH_BSLASH) begin
            phase_nxt = val_str ? PH_VESC : PH_KESC;
          end else if (c < CTRL_LIMIT) begin
            err = ERR_CTRL_CHAR;
          end else begin
            run.res[n] = mk_res(val_str ? EV_VAL_BYTE : EV_KEY_BYTE, c, 32'd0, ERR_NONE);
            n = n + 2'd1;
          end
        end
        PH_KESC, PH_VESC: begin
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_d = c;
            CH_B:    esc_d = 8'h08;
            CH_F:    esc_d = 8'h0c;
            CH_N:    esc_d = 8'h0a;
            CH_R:    esc_d = 8'h0d;
            CH_T:    esc_d = 8'h09;
            CH_U:    esc_d = c;
            default: err = ERR_BAD_ESC;
          endcase
          if (c == CH_U) begin
            hex_left_nxt = 3'd4;
            cp_nxt       = 16'd0;
            phase_nxt    = val_str ? PH_VHEX : PH_KHEX;
          end else if (err == ERR_NONE) begin
            run.res[n] = mk_res(val_str ? EV_VAL_BYTE : EV_KEY_BYTE, esc_d, 32'd0, ERR_NONE);
            n = n + 2'd1;
            phase_nxt = val_str ? PH_VSTR : PH_KSTR;
          end
        end
        PH_KHEX, PH_VHEX: begin
          if (!is_hex) begin
            err = ERR_BAD_HEX;
          end else begin
            cp_nxt       = cp_shift;
            hex_left_nxt = hex_left_r - 3'd1;
            if (hex_left_nxt == 3'd0) begin
              if (cp_shift > ASCII_MAX) begin
                err = ERR_UNI_BIG;
              end else begin
                run.res[n] = mk_res(val_str ? EV_VAL_BYTE : EV_KEY_BYTE, cp_shift[7:0],
                                    32'd0, ERR_NONE);
                n = n + 2'd1;
                phase_nxt = val_str ? PH_VSTR : PH_KSTR;
              end
            end
          end
        end
        PH_COLON: begin
          if (c == CH_COLON) phase_nxt = PH_VALUE;
          else if (!is_ws) err = ERR_EXP_CHAR;
        end
        PH_VALUE: begin
          if (is_ws) begin
          end else if (c == CH_QUOTE) begin
            phase_nxt = PH_VSTR;
          end else if (c == CH_LBRACK) begin
            run.res[n] = mk_res(EV_ARR_START, 8'd0, 32'd0, ERR_NONE);
            n = n + 2'd1;
            phase_nxt = PH_ARR_FIRST;
          end else begin
            err = ERR_UNSUPPORTED;
          end
        end
        PH_ARR_FIRST, PH_ARR_NEXT: begin
          if (is_ws) begin
          end else if (c == CH_RBRACK && phase_r == PH_ARR_FIRST) begin
            run.res[n] = mk_res(EV_ARR_END, 8'd0, 32'd0, ERR_NONE);
            n = n + 2'd1;
            phase_nxt = PH_AFTER_VALUE;
          end else if (is_dig) begin
            acc_nxt   = NUMBER_BITS'(c[3:0]);
            phase_nxt = PH_NUM;
          end else begin
            err = ERR_EXP_NUMBER;
          end
        end
        PH_NUM: begin
          if (is_dig) begin
            if (|prod[PW-1:NUMBER_BITS]) err = ERR_OVERFLOW;
            else acc_nxt = prod[NUMBER_BITS-1:0];
          end else begin
            run.res[n] = mk_res(EV_ELEMENT, 8'd0, acc_ext[31:0], ERR_NONE);
            n = n + 2'd1;
            acc_nxt = '0;
            if (is_ws) phase_nxt = PH_AFTER_NUM;
            else do_after = 1'b1;
          end
        end
        PH_AFTER_NUM: begin
          if (!is_ws) do_after = 1'b1;
        end
        PH_AFTER_VALUE: begin
          if (is_ws) begin
          end else if (c == CH_RBRACE) begin
            phase_nxt = PH_TRAIL;
          end else if (c == CH_COMMA) begin
            phase_nxt = PH_KEY;
          end else begin
            err = ERR_FIELD_SEP;
          end
        end
        PH_TRAIL: begin
          if (!is_ws) err = ERR_TRAILING;
        end
        default: err = ERR_EXP_CHAR;
      endcase

      if (do_after) begin
        if (c == CH_RBRACK) begin
          run.res[n] = mk_res(EV_ARR_END, 8'd0, 32'd0, ERR_NONE);
          n = n + 2'd1;
          phase_nxt = PH_AFTER_VALUE;
        end else if (c == CH_COMMA) begin
          phase_nxt = PH_ARR_NEXT;
        end else begin
          err = ERR_ARR_SEP;
        end
      end

      acc_ext = AccW'(acc_nxt);
      if (err != ERR_NONE) begin
        run.res[n] = mk_res(EV_ERROR, 8'd0, 32'd0, err);
        n = n + 2'd1;
        skip_nxt = 1'b1;
      end else if (last) begin
        if (phase_nxt == PH_TRAIL) begin
          run.res[n] = mk_res(EV_DONE, 8'd0, 32'd0, ERR_NONE);
          n = n + 2'd1;
        end else begin
          if (phase_nxt == PH_NUM) begin
            run.res[n] = mk_res(EV_ELEMENT, 8'd0, acc_ext[31:0], ERR_NONE);
            n = n + 2'd1;
          end
          run.res[n] = mk_res(EV_ERROR, 8'd0, 32'd0, end_code(phase_nxt));
          n = n + 2'd1;
        end
      end
    end

    if (last) begin
      phase_nxt    = PH_OPEN;
      hex_left_nxt = 3'd0;
      cp_nxt       = 16'd0;
      acc_nxt      = '0;
      skip_nxt     = 1'b0;
    end
    run.cnt = n;
  end

  assign push = accept && (run.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPEN;
      hex_left_r <= 3'd0;
      cp_r       <= 16'd0;
      acc_r      <= '0;
      skip_r     <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hex_left_r <= hex_left_nxt;
      cp_r       <= cp_nxt;
      acc_r      <= acc_nxt;
      skip_r     <= skip_nxt;
    end
  end

  `JOLP_ASSERT_IMP(a_skip_silent, clk, rst_n, accept && skip_r, !push, "item while skipping gave results")

endmodule

// ===== design/jolp_queue.sv =====
// Run queue between front and back: four entries of whole per-byte runs.
// Depends on jolp_pkg and the assertion macro header.
`include "json_object_line_parser_core_macros.svh"

module jolp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jolp_pkg::run_t wr_run,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output jolp_pkg::run_t head
);
  import jolp_pkg::*;

  run_t           mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCw-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == QCw'(QDepth));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCw'(do_push) - QCw'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `JOLP_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full, "run pushed into full queue")
  `JOLP_ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > QCw'(QDepth), "queue count beyond depth")

endmodule

// ===== design/jolp_back.sv =====
// Back end: output register that hands out the results of each run one at a time.
// Depends on jolp_pkg and the assertion macro header.
`include "json_object_line_parser_core_macros.svh"

module jolp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  jolp_pkg::run_t      head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output jolp_pkg::out_item_t out_item
);
  import jolp_pkg::*;

  run_t       run_r, run_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic       last_res, take;
  res_t       cur;

  assign last_res  = (idx_r == run_r.cnt - 2'd1);
  assign take      = valid_r && out_pop;
  assign q_pop     = q_valid && (!valid_r || (take && last_res));
  assign out_empty = !valid_r;
  assign cur       = run_r.res[idx_r];

  always_comb begin
    out_item.event_res   = cur.event_res;
    out_item.char_out    = cur.char_out;
    out_item.number      = cur.number;
    out_item.error_code  = cur.error_code;
    out_item.last_of_run = last_res;
  end

  always_comb begin
    run_nxt   = run_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (q_pop) begin
      run_nxt   = head;
      idx_nxt   = 2'd0;
      valid_nxt = 1'b1;
    end else if (take) begin
      if (last_res) valid_nxt = 1'b0;
      else idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  `JOLP_ASSERT_IMP(a_idx_in_run, clk, rst_n, valid_r, (run_r.cnt != 2'd0) && (idx_r < run_r.cnt), "result index outside run")
  `JOLP_ASSERT_NEXT(a_load_when_idle, clk, rst_n, !valid_r && q_valid, valid_r, "waiting run not loaded")

endmodule

// ===== design/json_object_line_parser_core.sv =====
// Top level of the JSON object line parser: front, run queue and back.
// Depends on jolp_pkg, jolp_front, jolp_queue and jolp_back.
//
//  channel | direction | handshake         | payload
//  in_     | in        | in_push / in_full | in_item  (in_byte, end_of_text)
//  out_    | out       | out_pop / out_empty | out_item (event, char, number, error, last)
//
//  One byte is taken per cycle while the run queue has room; its results leave
//  one per cycle from the output register while out_pop is high, so a byte with
//  three results holds the output side for all three. The four-entry run queue
//  absorbs this. Bytes with no result never enter the queue. out_pop low stalls
//  only the back end until the queue fills, then in_full rises.
module json_object_line_parser_core #(
  parameter int NUMBER_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  jolp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output jolp_pkg::out_item_t out_item
);
  import jolp_pkg::*;

  logic accept, f_push, q_full, q_valid, q_pop;
  run_t f_run, q_head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  jolp_front #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_item(in_item),
    .push   (f_push),
    .run    (f_run)
  );

  jolp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wr_run (f_run),
    .full   (q_full),
    .pop    (q_pop),
    .q_valid(q_valid),
    .head   (q_head)
  );

  jolp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (q_head),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule
